// ----- src/cpvb_pkg.sv -----
// Shared types, codes and constants for the convex polygon vertex builder.
package cpvb_pkg;

    localparam int MAX_VERTS_DEF = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_NOTCVX  = 3'd2;
    localparam logic [2:0] ST_CLOSED  = 3'd3;
    localparam logic [2:0] ST_REFUSED = 3'd4;
    localparam logic [2:0] ST_REMOVED = 3'd5;
    localparam logic [2:0] ST_EMPTY   = 3'd6;
    localparam logic [2:0] ST_CLEARED = 3'd7;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } t_in_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         point_count;
        logic signed [15:0] box_min_x;
        logic signed [15:0] box_min_y;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_DUP,
        S_CROSS,
        S_DRAIN,
        S_CHECK,
        S_BOX,
        S_BOX_WAIT,
        S_BOX_SET,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load_req;
        logic decide;
        logic dup_chk;
        logic cp_rd;
        logic box_rd;
        logic box_first;
        logic check;
        logic box_set;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic to_dup;
        logic to_box;
        logic bad;
        logic out_free;
    } t_stat;

endpackage

// ----- src/cpvb_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module cpvb_ram import cpvb_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = MAX_VERTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- src/cpvb_datapath.sv -----
// Datapath: point store, checks, cross-product pipeline, box and result register.
module cpvb_datapath import cpvb_pkg::*; #(
    parameter int MAX_VERTS = MAX_VERTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  logic [$clog2(MAX_VERTS)-1:0]   i_addr_a,
    input  logic [$clog2(MAX_VERTS)-1:0]   i_addr_b,
    input  t_in_req                        i_in_req,
    input  logic                           i_out_stall,
    output t_stat                          o_stat,
    output logic [$clog2(MAX_VERTS+1)-1:0] o_count,
    output logic                           o_out_valid,
    output t_out_req                       o_out_req
);

    localparam int AW = $clog2(MAX_VERTS);
    localparam int CW = $clog2(MAX_VERTS + 1);

    logic [1:0]         r_op;
    logic signed [15:0] r_px, r_py;
    logic [CW-1:0]      r_count;
    logic signed [15:0] r_first_x, r_first_y;
    logic signed [15:0] r_bmin_x, r_bmin_y;
    logic [15:0]        r_bw, r_bh;
    logic [2:0]         r_status;
    logic               r_bad, r_first_pos;
    logic               r_dup_v, r_cp_v;
    logic [1:0]         r_loads;
    logic [31:0]        r_w1, r_w2;
    logic               r_s1_v, r_s1_first, r_s2_v, r_s2_first;
    logic signed [16:0] r_ax, r_ay, r_bx, r_by;
    logic signed [33:0] r_p1, r_p2;
    logic               r_box_v, r_box_first;
    logic signed [15:0] r_lo_x, r_lo_y, r_hi_x, r_hi_y;
    logic               r_out_valid;
    t_out_req           r_out;

    logic        full, match, add_ok, we;
    logic [31:0] rdata_a, rdata_b;
    logic signed [15:0] d_x, d_y;
    logic signed [34:0] cp;
    logic        pos;
    logic [15:0] span_x, span_y;

    assign full   = r_count >= CW'(MAX_VERTS);
    assign match  = (r_count != '0) && (r_px == r_first_x) && (r_py == r_first_y);
    assign add_ok = (r_op == OP_ADD) && !full && !match;
    assign we     = i_cmd.decide && add_ok;

    cpvb_ram #(.WIDTH(32), .DEPTH(MAX_VERTS)) u_store (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (r_count[AW-1:0]),
        .i_wdata  ({r_px, r_py}),
        .i_raddr_a(i_addr_a),
        .i_raddr_b(i_addr_b),
        .o_rdata_a(rdata_a),
        .o_rdata_b(rdata_b)
    );

    assign d_x    = $signed(rdata_a[31:16]);
    assign d_y    = $signed(rdata_a[15:0]);
    assign cp     = {r_p1[33], r_p1} - {r_p2[33], r_p2};
    assign pos    = !cp[34] && (cp != '0);
    assign span_x = r_hi_x - r_lo_x;
    assign span_y = r_hi_y - r_lo_y;

    always_comb begin
        o_stat.to_dup   = add_ok && (r_count >= CW'(3));
        o_stat.to_box   = (add_ok && (r_count < CW'(3)))
                       || ((r_op == OP_REMOVE) && (r_count > CW'(1)));
        o_stat.bad      = r_bad;
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

    // Store payload, first point, corner pipeline, box bounds and result data; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op <= i_in_req.opcode;
            r_px <= i_in_req.point_x;
            r_py <= i_in_req.point_y;
        end
        if (we && (r_count == '0)) begin
            r_first_x <= r_px;
            r_first_y <= r_py;
        end
        if (r_cp_v) begin
            r_w1 <= r_w2;
            r_w2 <= rdata_a;
        end
        // corner: P[i] = w1, P[i+1] = w2, P[i+2] = incoming word
        r_ax <= 17'(d_x) - 17'($signed(r_w2[31:16]));
        r_ay <= 17'(d_y) - 17'($signed(r_w2[15:0]));
        r_bx <= 17'($signed(r_w1[31:16])) - 17'($signed(r_w2[31:16]));
        r_by <= 17'($signed(r_w1[15:0])) - 17'($signed(r_w2[15:0]));
        r_p1 <= r_ax * r_by;
        r_p2 <= r_ay * r_bx;
        if (r_box_v) begin
            if (r_box_first || d_x < r_lo_x) r_lo_x <= d_x;
            if (r_box_first || d_x > r_hi_x) r_hi_x <= d_x;
            if (r_box_first || d_y < r_lo_y) r_lo_y <= d_y;
            if (r_box_first || d_y > r_hi_y) r_hi_y <= d_y;
        end
        if (i_cmd.out_load) begin
            r_out.status      <= r_status;
            r_out.point_count <= 6'(r_count);
            r_out.box_min_x   <= r_bmin_x;
            r_out.box_min_y   <= r_bmin_y;
            r_out.box_width   <= r_bw;
            r_out.box_height  <= r_bh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_bmin_x    <= '0;
            r_bmin_y    <= '0;
            r_bw        <= '0;
            r_bh        <= '0;
            r_status    <= ST_ADDED;
            r_bad       <= 1'b0;
            r_first_pos <= 1'b0;
            r_dup_v     <= 1'b0;
            r_cp_v      <= 1'b0;
            r_loads     <= '0;
            r_s1_v      <= 1'b0;
            r_s1_first  <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s2_first  <= 1'b0;
            r_box_v     <= 1'b0;
            r_box_first <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_dup_v     <= i_cmd.dup_chk;
            r_cp_v      <= i_cmd.cp_rd;
            r_box_v     <= i_cmd.box_rd;
            r_box_first <= i_cmd.box_first;
            r_s1_v      <= r_cp_v && (r_loads >= 2'd2);
            r_s1_first  <= r_cp_v && (r_loads == 2'd2);
            r_s2_v      <= r_s1_v;
            r_s2_first  <= r_s1_first;
            if (r_cp_v && r_loads != 2'd3) begin
                r_loads <= r_loads + 2'd1;
            end
            if (r_dup_v && rdata_a == rdata_b) begin
                r_bad <= 1'b1;
            end
            if (r_s2_v) begin
                if (r_s2_first) begin
                    r_first_pos <= pos;
                end else if (pos != r_first_pos) begin
                    r_bad <= 1'b1;
                end
            end

            if (i_cmd.decide) begin
                r_bad   <= 1'b0;
                r_loads <= '0;
                case (r_op)
                    OP_ADD: begin
                        if (full) begin
                            r_status <= ST_FULL;
                        end else if (match) begin
                            if (r_count >= CW'(3)) begin
                                r_count  <= '0;
                                r_bmin_x <= '0;
                                r_bmin_y <= '0;
                                r_bw     <= '0;
                                r_bh     <= '0;
                                r_status <= ST_CLOSED;
                            end else begin
                                r_status <= ST_REFUSED;
                            end
                        end else if (r_count < CW'(3)) begin
                            r_count  <= r_count + CW'(1);
                            r_status <= ST_ADDED;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_count == '0) begin
                            r_status <= ST_EMPTY;
                        end else begin
                            r_count  <= r_count - CW'(1);
                            r_status <= ST_REMOVED;
                            if (r_count == CW'(1)) begin
                                r_bmin_x <= '0;
                                r_bmin_y <= '0;
                                r_bw     <= '0;
                                r_bh     <= '0;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        r_count  <= '0;
                        r_bmin_x <= '0;
                        r_bmin_y <= '0;
                        r_bw     <= '0;
                        r_bh     <= '0;
                        r_status <= ST_CLEARED;
                    end
                    default: begin
                        r_count  <= '0;
                        r_bmin_x <= '0;
                        r_bmin_y <= '0;
                        r_bw     <= '0;
                        r_bh     <= '0;
                        r_status <= ST_CLEARED;
                    end
                endcase
            end

            if (i_cmd.check) begin
                if (r_bad) begin
                    r_status <= ST_NOTCVX;
                end else begin
                    r_count  <= r_count + CW'(1);
                    r_status <= ST_ADDED;
                end
            end

            if (i_cmd.box_set) begin
                r_bmin_x <= r_lo_x;
                r_bmin_y <= r_lo_y;
                r_bw     <= span_x;
                r_bh     <= span_y;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_count     = r_count;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ----- src/cpvb_ctrl.sv -----
// Controller: sequences decide, duplicate scan, corner scan, box scan and result load.
module cpvb_ctrl import cpvb_pkg::*; #(
    parameter int MAX_VERTS = MAX_VERTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  t_stat                          i_stat,
    input  logic [$clog2(MAX_VERTS+1)-1:0] i_count,
    output t_cmd                           o_cmd,
    output logic [$clog2(MAX_VERTS)-1:0]   o_addr_a,
    output logic [$clog2(MAX_VERTS)-1:0]   o_addr_b
);

    localparam int AW = $clog2(MAX_VERTS);
    localparam int CW = $clog2(MAX_VERTS + 1);

    t_state        r_state, n_state;
    logic [CW:0]   r_i, n_i, r_j, n_j, r_m, n_m;
    logic [2:0]    r_drain, n_drain;
    logic [CW:0]   nn, wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_m     <= n_m;
            r_drain <= n_drain;
        end
    end

    // nn: point count including the candidate
    assign nn   = {1'b0, i_count} + (CW+1)'(1);
    assign wrap = (r_m < nn) ? r_m : (r_m - nn);

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_m        = r_m;
        n_drain    = r_drain;
        o_cmd      = '0;
        o_addr_a   = '0;
        o_addr_b   = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load_req = i_in_valid;
                if (i_in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_i = '0;
                n_j = (CW+1)'(1);
                n_m = '0;
                if (i_stat.to_dup)      n_state = S_DUP;
                else if (i_stat.to_box) n_state = S_BOX;
                else                    n_state = S_RESULT;
            end
            S_DUP: begin
                o_cmd.dup_chk = 1'b1;
                o_addr_a = r_i[AW-1:0];
                o_addr_b = r_j[AW-1:0];
                if (r_j == nn - (CW+1)'(1)) begin
                    if (r_i == nn - (CW+1)'(2)) begin
                        n_m     = '0;
                        n_state = S_CROSS;
                    end else begin
                        n_i = r_i + (CW+1)'(1);
                        n_j = r_i + (CW+1)'(2);
                    end
                end else begin
                    n_j = r_j + (CW+1)'(1);
                end
            end
            S_CROSS: begin
                o_cmd.cp_rd = 1'b1;
                o_addr_a = wrap[AW-1:0];
                if (r_m == nn + (CW+1)'(1)) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_m = r_m + (CW+1)'(1);
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 3'd1;
                if (r_drain == 3'd3) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_m = '0;
                n_state = i_stat.bad ? S_RESULT : S_BOX;
            end
            S_BOX: begin
                o_cmd.box_rd    = 1'b1;
                o_cmd.box_first = (r_m == '0);
                o_addr_a = r_m[AW-1:0];
                if (r_m == {1'b0, i_count} - (CW+1)'(1)) n_state = S_BOX_WAIT;
                else n_m = r_m + (CW+1)'(1);
            end
            S_BOX_WAIT: begin
                n_state = S_BOX_SET;
            end
            S_BOX_SET: begin
                o_cmd.box_set = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/convex_polygon_vertex_builder.sv -----
// Top level of the convex polygon vertex builder.
//
// Builds a convex polygon one request at a time from signed Q12.4 points and
// returns one result request per input request: a status code, the point
// count and the bounding box (min x, min y, width, height) after the
// operation. One request is worked on at a time; the input stalls until its
// result has been loaded into the output register. An add or remove that
// needs the box rebuilt scans the store, one stored point read per cycle.
// An add that yields n >= 4 points first runs a pairwise duplicate scan of
// all point pairs (two store reads per cycle), then a corner scan of n+2
// reads through a three-stage cross-product pipeline, then the drain and
// check states, then the box scan. The point store is one dual-read RAM;
// its contents need no clearing after reset.
module convex_polygon_vertex_builder import cpvb_pkg::*; #(
    parameter int MAX_VERTS = MAX_VERTS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    t_cmd  cmd;
    t_stat stat;
    logic [$clog2(MAX_VERTS+1)-1:0] count;
    logic [$clog2(MAX_VERTS)-1:0]   addr_a, addr_b;

    // Sequence each request through decide, scans and result load.
    cpvb_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_stat    (stat),
        .i_count   (count),
        .o_cmd     (cmd),
        .o_addr_a  (addr_a),
        .o_addr_b  (addr_b)
    );

    // Hold the points, the box and the result register.
    cpvb_datapath #(.MAX_VERTS(MAX_VERTS)) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_addr_a   (addr_a),
        .i_addr_b   (addr_b),
        .i_in_req   (i_in_req),
        .i_out_stall(i_out_stall),
        .o_stat     (stat),
        .o_count    (count),
        .o_out_valid(o_out_valid),
        .o_out_req  (o_out_req)
    );

endmodule

// ----- sim/convex_polygon_vertex_builder_tb.sv -----
// Self-checking testbench for the convex polygon vertex builder.
module convex_polygon_vertex_builder_tb;
    import cpvb_pkg::*;

    localparam int NVERT = MAX_VERTS_DEF;

    // Predict each request's result and match results against it in order.
    class poly_scoreboard;
        logic signed [15:0] vx[NVERT];
        logic signed [15:0] vy[NVERT];
        int                 count;
        logic signed [15:0] min_x, min_y;
        logic [15:0]        width, height;
        t_out_req           pending[$];
        int                 errors;
        int                 matched;

        function void clear_state();
            count = 0;
            min_x = 0; min_y = 0; width = 0; height = 0;
            pending.delete();
            errors = 0;
            matched = 0;
        endfunction

        function void rebuild_box();
            int lx, ly, hx, hy;
            if (count == 0) begin
                min_x = 0; min_y = 0; width = 0; height = 0;
                return;
            end
            lx = vx[0]; hx = vx[0]; ly = vy[0]; hy = vy[0];
            for (int i = 1; i < count; i++) begin
                if (vx[i] < lx) lx = vx[i];
                if (vx[i] > hx) hx = vx[i];
                if (vy[i] < ly) ly = vy[i];
                if (vy[i] > hy) hy = vy[i];
            end
            min_x = lx; min_y = ly;
            width = 16'(hx - lx); height = 16'(hy - ly);
        endfunction

        // Duplicate scan plus same-turn test over n points.
        function bit is_convex(int n);
            bit first_pos, pos;
            longint ax, ay, bx, by, cp;
            int i1, i2;
            first_pos = 0;
            if (n < 4) return 1;
            for (int i = 0; i < n; i++) begin
                for (int j = i + 1; j < n; j++)
                    if (vx[i] == vx[j] && vy[i] == vy[j]) return 0;
                i1 = (i + 1) % n;
                i2 = (i + 2) % n;
                ax = longint'(vx[i2]) - vx[i1];
                ay = longint'(vy[i2]) - vy[i1];
                bx = longint'(vx[i]) - vx[i1];
                by = longint'(vy[i]) - vy[i1];
                cp = ax * by - ay * bx;
                pos = cp > 0;
                if (i == 0) first_pos = pos;
                else if (pos != first_pos) return 0;
            end
            return 1;
        endfunction

        function void note_request(t_in_req r);
            t_out_req e;
            logic [2:0] st;
            if (r.opcode == OP_ADD) begin
                if (count >= NVERT) st = ST_FULL;
                else if (count > 0 && vx[0] == r.point_x && vy[0] == r.point_y) begin
                    if (count >= 3) begin
                        count = 0;
                        rebuild_box();
                        st = ST_CLOSED;
                    end else st = ST_REFUSED;
                end else begin
                    vx[count] = r.point_x;
                    vy[count] = r.point_y;
                    if (is_convex(count + 1)) begin
                        count++;
                        rebuild_box();
                        st = ST_ADDED;
                    end else st = ST_NOTCVX;
                end
            end else if (r.opcode == OP_REMOVE) begin
                if (count == 0) st = ST_EMPTY;
                else begin
                    count--;
                    rebuild_box();
                    st = ST_REMOVED;
                end
            end else begin
                // Clear, and the unused opcode acts the same.
                count = 0;
                rebuild_box();
                st = ST_CLEARED;
            end
            e.status = st;
            e.point_count = 6'(count);
            e.box_min_x = min_x;
            e.box_min_y = min_y;
            e.box_width = width;
            e.box_height = height;
            pending.push_back(e);
        endfunction

        task check_result(t_out_req got);
            t_out_req e;
            if (pending.size() == 0) begin
                report("result with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status) report("status");
            if (got.point_count != e.point_count) report("point_count");
            if (got.box_min_x != e.box_min_x) report("box_min_x");
            if (got.box_min_y != e.box_min_y) report("box_min_y");
            if (got.box_width != e.box_width) report("box_width");
            if (got.box_height != e.box_height) report("box_height");
            matched++;
        endtask

        task report(string what);
            errors++;
            if (errors <= 40) $display("mismatch at %0t: %s", $realtime, what);
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_in_req  in_req;
    logic     out_valid;
    logic     out_stall;
    t_out_req out_req;

    poly_scoreboard sb;
    bit             stim_done;
    int             sent;
    int             stall_long;
    int             out_hold;

    convex_polygon_vertex_builder #(.MAX_VERTS(NVERT)) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_req  (out_req)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one; long stretches with none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (stall_long > 0) return 0;
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(logic [1:0] op, logic signed [15:0] x,
                                logic signed [15:0] y);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_req.opcode = op;
        in_req.point_x = x;
        in_req.point_y = y;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(in_req);
        sent++;
        @(negedge clk);
    endtask

    // Random stall on the result side; sample at the rising edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_req);
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_hold = 0;
        end else if (out_hold > 0) begin
            out_stall <= 1'b1;
            out_hold--;
        end else begin
            out_stall <= 1'b0;
            out_hold = pick_gap();
        end
    end

    // Walk a regular-ish convex polygon of k points, random center and size.
    task automatic send_convex(int k, bit close_it);
        int cx, cy, rad;
        real ang;
        int px, py, px0, py0;
        cx = $urandom_range(0, 20000) - 10000;
        cy = $urandom_range(0, 20000) - 10000;
        rad = $urandom_range(200, 12000);
        for (int i = 0; i < k; i++) begin
            ang = 6.2831853 * i / k;
            px = cx + $rtoi(rad * $cos(ang));
            py = cy + $rtoi(rad * $sin(ang));
            if (i == 0) begin px0 = px; py0 = py; end
            send_request(OP_ADD, 16'(px), 16'(py));
        end
        if (close_it) send_request(OP_ADD, 16'(px0), 16'(py0));
    endtask

    task automatic send_noise();
        int r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        op = (r < 70) ? OP_ADD : (r < 85) ? OP_REMOVE : (r < 95) ? OP_CLEAR : 2'd3;
        send_request(op, 16'($urandom), 16'($urandom));
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        stim_done = 0;
        sent = 0;
        stall_long = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty remove, refused close, extremes, a square, full store.
        send_request(OP_REMOVE, 16'sd0, 16'sd0);
        send_request(OP_ADD, 16'sh8000, 16'sh7fff);
        send_request(OP_ADD, 16'sh8000, 16'sh7fff);
        send_request(OP_ADD, 16'sh7fff, 16'sh8000);
        send_request(OP_ADD, 16'sh7fff, 16'sh7fff);
        send_request(OP_ADD, 16'sh8000, 16'sh8000);
        send_request(OP_ADD, 16'sh8000, 16'sh7fff);
        send_request(OP_ADD, 16'sh1234, 16'sh0000);
        send_request(OP_REMOVE, 16'sd0, 16'sd0);
        send_request(OP_CLEAR, 16'shffff, 16'shffff);
        send_request(OP_ADD, 16'sd0, 16'sd0);
        send_request(OP_ADD, 16'sd16, 16'sd0);
        send_request(OP_ADD, 16'sd16, 16'sd16);
        send_request(OP_ADD, 16'sd0, 16'sd16);
        send_request(OP_ADD, 16'sd8, 16'sd8);
        send_request(OP_ADD, 16'sd16, 16'sd16);
        send_request(OP_ADD, 16'sd0, 16'sd0);
        send_request(OP_ADD, 16'sd5, 16'sd5);
        send_request(OP_REMOVE, 16'sd0, 16'sd0);
        send_request(2'd3, 16'sd0, 16'sd0);
        stall_long = 1;
        send_convex(NVERT, 1'b0);
        send_request(OP_ADD, 16'sd1, 16'sd1);
        send_request(OP_ADD, 16'sh8000, 16'sh8000);
        stall_long = 0;
        repeat (NVERT) send_request(OP_REMOVE, 16'sd0, 16'sd0);
        send_request(OP_REMOVE, 16'sd0, 16'sd0);

        // Random: mostly well-formed polygons with noise between them.
        while (sent < 1000) begin
            stall_long = ($urandom_range(0, 9) == 0) ? 1 : 0;
            case ($urandom_range(0, 5))
                0, 1: send_convex($urandom_range(3, 8), 1'($urandom_range(0, 1)));
                2: send_convex($urandom_range(9, NVERT), 1'($urandom_range(0, 1)));
                3: begin
                    send_convex($urandom_range(4, 10), 1'b0);
                    repeat ($urandom_range(1, 4)) send_noise();
                end
                default: repeat ($urandom_range(1, 6)) send_noise();
            endcase
            if ($urandom_range(0, 3) == 0) send_request(OP_CLEAR, 16'($urandom), 16'($urandom));
        end
        in_valid <= 1'b0;
        stall_long = 1;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 sent, sb.matched, sb.errors);
        $display("covered adds, closes, removes, clears, full store and rejects");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: worst case is ~1100 requests plus stalls.
    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/cpvb_pkg.sv
src/cpvb_ram.sv
src/cpvb_datapath.sv
src/cpvb_ctrl.sv
src/convex_polygon_vertex_builder.sv
sim/convex_polygon_vertex_builder_tb.sv
